/* rtl/chd_pkg.sv */
package chd_pkg;

    localparam int CLASS_SLOTS = 32;
    localparam int SLOT_W      = 5;
    localparam int FIRST_W     = 32;
    localparam int BASE_W      = 12;
    localparam int LEN_W       = 6;
    localparam int SPEC_W      = 13;
    localparam int CADDR_W     = 12;
    localparam int CVAL_W      = 24;
    localparam int BYTE_W      = 8;
    localparam int BUF_W       = 64;
    localparam int CNT_W       = 7;
    localparam int VAL_W       = 25;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH       = 3'd0,
        ACT_LOAD_CLASS = 3'd1,
        ACT_LOAD_COLOR = 3'd2,
        ACT_DECODE     = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NEED_MORE = 2'd1,
        STAT_DROPPED   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_SUM,
        ST_MOD,
        ST_READ,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                 decode;
        logic [ACT_W-1:0]     action;
        logic [BYTE_W-1:0]    byte_in;
        logic [SLOT_W-1:0]    class_slot;
        logic [FIRST_W-1:0]   class_first_code;
        logic [BASE_W-1:0]    class_base;
        logic [LEN_W-1:0]     class_length;
        logic [SPEC_W-1:0]    class_special;
        logic [CADDR_W-1:0]   color_addr;
        logic [CVAL_W-1:0]    color_value;
    } item_t;

    typedef struct packed {
        logic [FIRST_W-1:0] first;
        logic [BASE_W-1:0]  base;
        logic [LEN_W-1:0]   len;
        logic [SPEC_W-1:0]  special;
    } class_t;

endpackage

/* rtl/chd_front.sv */
module chd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [chd_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic [chd_pkg::ACT_W-1:0]            s_tuser,
    output logic                                 q_valid,
    input  logic                                 q_pop,
    output chd_pkg::item_t                       q_item
);

    chd_pkg::item_t entry_reg [2];
    chd_pkg::item_t in_item;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;

    always_comb
    begin
        in_item.decode           = (s_tuser == chd_pkg::ACT_DECODE);
        in_item.action           = s_tuser;
        in_item.byte_in          = s_tdata[7:0];
        in_item.class_slot       = s_tdata[12:8];
        in_item.class_first_code = s_tdata[44:13];
        in_item.class_base       = s_tdata[56:45];
        in_item.class_length     = s_tdata[62:57];
        in_item.class_special    = s_tdata[75:63];
        in_item.color_addr       = s_tdata[87:76];
        in_item.color_value      = s_tdata[111:88];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/chd_back.sv */
module chd_back #(
    parameter int COLOR_DEPTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  chd_pkg::item_t                    q_item,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [chd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [chd_pkg::STAT_W-1:0]        m_tuser
);

    localparam int  AW      = (COLOR_DEPTH > 1) ? $clog2(COLOR_DEPTH) : 1;
    localparam bit  IS_POW2 = ((COLOR_DEPTH & (COLOR_DEPTH - 1)) == 0);
    localparam int  SUM_W   = chd_pkg::FIRST_W + 1;
    localparam int  HALF_W  = 16;
    localparam int  MAG_W   = SUM_W + 2;
    localparam int  PROD_W  = SUM_W + MAG_W;
    localparam int  RSH     = SUM_W + AW;
    localparam logic [63:0] MAG_FULL =
        ((64'd1 << RSH) + 64'(COLOR_DEPTH) - 64'd1) / 64'(COLOR_DEPTH);
    localparam logic [MAG_W-1:0] MAG     = MAG_FULL[MAG_W-1:0];
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(COLOR_DEPTH);

    chd_pkg::state_t state_reg, state_next;
    chd_pkg::item_t  cur_reg;
    chd_pkg::class_t cls_reg [chd_pkg::CLASS_SLOTS];
    chd_pkg::class_t csel;

    logic [chd_pkg::CVAL_W-1:0]  color_mem [COLOR_DEPTH];
    logic [chd_pkg::CVAL_W-1:0]  entry_reg;

    logic [chd_pkg::BUF_W-1:0]   buf_reg;
    logic [chd_pkg::CNT_W-1:0]   cnt_reg;
    logic [chd_pkg::FIRST_W-1:0] peek_reg;
    logic [chd_pkg::CLASS_SLOTS-1:1] ge_reg;
    logic [chd_pkg::FIRST_W-1:0] diff_reg;
    logic [chd_pkg::BASE_W-1:0]  base_reg;
    logic [chd_pkg::LEN_W-1:0]   len_reg;
    logic [chd_pkg::SPEC_W-1:0]  special_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [HALF_W+MAG_W-1:0]     plo_reg;
    logic [SUM_W-1:0]            quot_reg;
    logic [AW-1:0]               rem_reg;
    logic [1:0]                  idx_reg;
    logic [AW-1:0]               rd_addr;

    logic                        out_valid_reg;
    logic [chd_pkg::STAT_W-1:0]  out_stat_reg;
    logic [chd_pkg::VAL_W-1:0]   out_val_reg;
    logic [chd_pkg::CNT_W-1:0]   out_cnt_reg;

    logic                        out_free;
    logic                        exec_fire;
    logic                        mod_done;

    logic [95:0]                 peek_wide;
    logic [chd_pkg::FIRST_W-1:0] peek_c;
    logic [chd_pkg::CLASS_SLOTS-1:1] ge_c;
    logic [chd_pkg::SLOT_W-1:0]  sel;
    logic [chd_pkg::FIRST_W-1:0] diff_c;
    logic [SUM_W-HALF_W+MAG_W-1:0] phi_c;
    logic [PROD_W-1:0]           prod_c;
    logic [SUM_W-1:0]            quot_c;
    logic [SUM_W-1:0]            qd_c;

    logic                        esc;
    logic [chd_pkg::CNT_W-1:0]   extra;
    logic [chd_pkg::CNT_W-1:0]   need;
    logic [chd_pkg::CNT_W-1:0]   cnt_mid;
    logic [chd_pkg::CNT_W-1:0]   cnt_fin;
    logic [23:0]                 raw24;
    logic [15:0]                 raw16;
    logic [chd_pkg::VAL_W-1:0]   dec_val;

    logic [chd_pkg::STAT_W-1:0]  res_stat;
    logic [chd_pkg::VAL_W-1:0]   res_val;
    logic [chd_pkg::CNT_W-1:0]   res_cnt;
    logic [chd_pkg::BUF_W-1:0]   res_buf;

    assign out_free = !out_valid_reg || m_tready;
    assign mod_done = IS_POW2 || (idx_reg == 2'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chd_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.decode ? chd_pkg::ST_CMP : chd_pkg::ST_EXEC;
                end
            end
            chd_pkg::ST_CMP:  state_next = chd_pkg::ST_SEL;
            chd_pkg::ST_SEL:  state_next = chd_pkg::ST_SUM;
            chd_pkg::ST_SUM:  state_next = IS_POW2 ? chd_pkg::ST_READ : chd_pkg::ST_MOD;
            chd_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = chd_pkg::ST_READ;
                end
            end
            chd_pkg::ST_READ: state_next = chd_pkg::ST_EXEC;
            chd_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = chd_pkg::ST_IDLE;
                end
            end
            default:          state_next = chd_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            chd_pkg::ST_IDLE: q_pop     = q_valid;
            chd_pkg::ST_EXEC: exec_fire = out_free;
            default:
            begin
                q_pop     = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // peek 32 bits; bits above the count are always zero
    assign peek_wide = {buf_reg, 32'b0} >> cnt_reg;
    assign peek_c    = peek_wide[31:0];

    always_comb
    begin
        for (int i = 1; i < chd_pkg::CLASS_SLOTS; i++)
        begin
            ge_c[i] = (peek_c >= cls_reg[i].first);
        end
    end

    // highest slot that matches together with every slot below it
    always_comb
    begin
        sel = chd_pkg::SLOT_W'(chd_pkg::CLASS_SLOTS - 1);
        for (int i = chd_pkg::CLASS_SLOTS - 1; i >= 1; i--)
        begin
            if (!ge_reg[i])
            begin
                sel = chd_pkg::SLOT_W'(i - 1);
            end
        end
    end

    assign csel = cls_reg[sel];

    always_comb
    begin
        if (csel.len == '0)
        begin
            diff_c = '0;
        end
        else
        begin
            diff_c = (peek_reg - csel.first) >> (6'd32 - csel.len);
        end
    end

    // remainder by reciprocal multiply: low half, high half and quotient, then subtract
    assign phi_c   = sum_reg[SUM_W-1:HALF_W] * MAG;
    assign prod_c  = {phi_c, HALF_W'(0)} + PROD_W'(plo_reg);
    assign quot_c  = SUM_W'(prod_c >> RSH);
    assign qd_c    = quot_reg * DEPTH_S;
    assign rd_addr = IS_POW2 ? sum_reg[AW-1:0] : rem_reg;

    // decode arithmetic
    always_comb
    begin
        esc     = (diff_reg < {19'b0, special_reg});
        extra   = '0;
        if (esc && entry_reg == '0)
        begin
            extra = 7'd24;
        end
        else if (esc && entry_reg == 24'd1)
        begin
            extra = 7'd16;
        end
        need    = {1'b0, len_reg} + extra;
        cnt_mid = cnt_reg - {1'b0, len_reg};
        cnt_fin = cnt_mid - extra;
        raw24   = 24'(buf_reg >> (cnt_mid - 7'd24));
        raw16   = 16'(buf_reg >> (cnt_mid - 7'd16));
        if (!esc)
        begin
            dec_val = {1'b0, entry_reg};
        end
        else if (entry_reg == '0)
        begin
            dec_val = {1'b0, raw24};
        end
        else if (entry_reg == 24'd1)
        begin
            dec_val = {9'h1ff, ~raw16};
        end
        else
        begin
            dec_val = 25'd1 - {1'b0, entry_reg};
        end
    end

    always_comb
    begin
        res_stat = chd_pkg::STAT_OK;
        res_val  = '0;
        res_cnt  = cnt_reg;
        res_buf  = buf_reg;
        case (cur_reg.action)
            chd_pkg::ACT_PUSH:
            begin
                if (cnt_reg > 7'd56)
                begin
                    res_stat = chd_pkg::STAT_DROPPED;
                end
                else
                begin
                    res_buf = {buf_reg[55:0], cur_reg.byte_in};
                    res_cnt = cnt_reg + 7'd8;
                end
            end
            chd_pkg::ACT_DECODE:
            begin
                if (cnt_reg < need)
                begin
                    res_stat = chd_pkg::STAT_NEED_MORE;
                end
                else
                begin
                    res_val = dec_val;
                    res_cnt = cnt_fin;
                    res_buf = buf_reg & ~({chd_pkg::BUF_W{1'b1}} << cnt_fin);
                end
            end
            chd_pkg::ACT_CLEAR:
            begin
                res_buf = '0;
                res_cnt = '0;
            end
            default:
            begin
                res_stat = chd_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chd_pkg::ST_IDLE;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < chd_pkg::CLASS_SLOTS; i++)
            begin
                cls_reg[i].first   <= '1;
                cls_reg[i].base    <= '0;
                cls_reg[i].len     <= '0;
                cls_reg[i].special <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                buf_reg       <= res_buf;
                cnt_reg       <= res_cnt;
                out_valid_reg <= 1'b1;
                if (cur_reg.action == chd_pkg::ACT_LOAD_CLASS)
                begin
                    cls_reg[cur_reg.class_slot].first   <= cur_reg.class_first_code;
                    cls_reg[cur_reg.class_slot].base    <= cur_reg.class_base;
                    cls_reg[cur_reg.class_slot].len     <= (cur_reg.class_length > 6'd32)
                                                           ? 6'd32 : cur_reg.class_length;
                    cls_reg[cur_reg.class_slot].special <= cur_reg.class_special;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == chd_pkg::ST_CMP)
        begin
            peek_reg <= peek_c;
            ge_reg   <= ge_c;
        end
        if (state_reg == chd_pkg::ST_SEL)
        begin
            diff_reg    <= diff_c;
            base_reg    <= csel.base;
            len_reg     <= csel.len;
            special_reg <= csel.special;
        end
        if (state_reg == chd_pkg::ST_SUM)
        begin
            sum_reg <= {1'b0, diff_reg} + {21'b0, base_reg};
            idx_reg <= 2'd2;
        end
        if (state_reg == chd_pkg::ST_MOD)
        begin
            if (idx_reg == 2'd2)
            begin
                plo_reg <= sum_reg[HALF_W-1:0] * MAG;
            end
            if (idx_reg == 2'd1)
            begin
                quot_reg <= quot_c;
            end
            if (idx_reg == 2'd0)
            begin
                rem_reg <= AW'(sum_reg - qd_c);
            end
            idx_reg <= idx_reg - 2'd1;
        end
        if (exec_fire)
        begin
            out_stat_reg <= res_stat;
            out_val_reg  <= res_val;
            out_cnt_reg  <= res_cnt;
        end
    end

    // colour memory
    always_ff @(posedge clk)
    begin
        if (exec_fire && cur_reg.action == chd_pkg::ACT_LOAD_COLOR
            && {20'b0, cur_reg.color_addr} < 32'(COLOR_DEPTH))
        begin
            color_mem[AW'(cur_reg.color_addr)] <= cur_reg.color_value;
        end
        if (state_reg == chd_pkg::ST_READ)
        begin
            entry_reg <= color_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {out_cnt_reg, out_val_reg};

endmodule

/* rtl/canonical_huffman_color_decoder.sv */
// Canonical Huffman colour decoder.
// Input stream (s_*): one beat per item; tuser carries the action (push byte,
// load class, load colour, decode, clear buffer), tdata the operand fields.
// Output stream (m_*): exactly one result beat per input beat, in order;
// tuser carries the status, tdata the decoded value and the buffered bit count.
// A two-entry queue sits in front of a sequencer that owns the bit buffer,
// the 32-slot class table and the colour memory.
// Push, load and clear items go from the queue head straight to the execute state.
// A decode steps through slot compare, class select, index add, the index
// remainder (the low index bits when COLOR_DEPTH is a power of two, else a
// reciprocal multiply and subtract), the colour memory read, and the final
// buffer update. One item is in the sequencer at a time.
// The result sits in an output register; while the receiver stalls the
// sequencer holds its finished item and the queue keeps taking beats until
// full. Reset clears the buffer, the count and the class table (first codes
// all ones); the colour memory holds no defined value until written.
module canonical_huffman_color_decoder #(
    parameter int COLOR_DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // byte_in, class_slot, class_first_code, class_base, class_length,
    // class_special, color_addr, color_value
    input  logic [chd_pkg::IN_DATA_W-1:0]        s_tdata,
    // action
    input  logic [chd_pkg::ACT_W-1:0]            s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // decoded_value, bits_buffered
    output logic [chd_pkg::OUT_DATA_W-1:0]       m_tdata,
    // status
    output logic [chd_pkg::STAT_W-1:0]           m_tuser
);

    logic           q_valid;
    logic           q_pop;
    chd_pkg::item_t q_item;

    chd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    chd_back #(
        .COLOR_DEPTH (COLOR_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:25] <= 7'd64))
        else $error("bit count beyond buffer size");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != chd_pkg::STAT_OK) |-> (m_tdata[24:0] == '0))
        else $error("non-zero value with failing status");

    a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == chd_pkg::STAT_DROPPED) |-> (m_tdata[31:25] > 7'd56))
        else $error("byte dropped with room left");

endmodule
